>>> rtl/gift_wrap_convex_hull_defines.svh
// Assertion macros used by the hull datapath.
`ifndef GIFT_WRAP_CONVEX_HULL_DEFINES_SVH
`define GIFT_WRAP_CONVEX_HULL_DEFINES_SVH

// Checks a property on every rising edge outside reset.
`define GWCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every rising edge, reset included.
`define GWCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/gwch_pkg.sv
// Types, constants and command codes of the gift-wrapping hull block.
package gwch_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS = 10;
  localparam int REF_START_DY = -100;

  localparam logic [1:0] PH_SQ = 2'd0;
  localparam logic [1:0] PH_LO = 2'd1;
  localparam logic [1:0] PH_HI = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  point_last;
  } point_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] hull_x;
    logic [COORD_BITS-1:0] hull_y;
    logic                  hull_last;
  } hull_t;

  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_scan;
    logic       rd_best;
    logic       ls_cmp;
    logic       init_walk;
    logic       set_cur;
    logic       first;
    logic       scan_start;
    logic       diff;
    logic       mul_en;
    logic       mul_q;
    logic [1:0] mul_phase;
    logic       decide;
    logic       emit;
    logic       emit_last;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic last_beat;
    logic last_idx;
    logic round_done;
    logic walk_stop;
    logic out_busy;
  } status_t;

endpackage

>>> rtl/gwch_datapath.sv
// Point store, cosine compare arithmetic and output register of the hull block.
module gwch_datapath #(
  parameter int MAX_POINTS = gwch_pkg::MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  gwch_pkg::point_t point,
  input  logic             point_valid,
  input  gwch_pkg::cmd_t   cmd,
  output gwch_pkg::status_t status,
  output gwch_pkg::hull_t  hull,
  output logic             hull_valid,
  input  logic             hull_stall
);
  import gwch_pkg::*;

  `include "gift_wrap_convex_hull_defines.svh"

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int W  = 2 * COORD_BITS + 2;

  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_data;
  logic [CW-1:0] count;
  logic [CW-1:0] round;
  logic [IW-1:0] idx;
  logic [IW-1:0] start_idx;
  logic [IW-1:0] best_idx;
  logic [COORD_BITS-1:0] min_x;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic signed [DW-1:0] rdx;
  logic signed [DW-1:0] rdy;
  logic signed [W:0] cand_dot;
  logic [W-1:0] cand_len;
  logic cand_zero;
  logic signed [W:0] best_dot;
  logic [W-1:0] best_len;
  logic found;
  logic [2*W-1:0] sq;
  logic [3*W-1:0] acc_p;
  logic [3*W-1:0] acc_q;

  logic fire;
  logic full;
  logic [COORD_BITS-1:0] rd_x;
  logic [COORD_BITS-1:0] rd_y;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [W:0] dot_c;
  logic [W-1:0] len_c;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_c;
  logic [W-1:0] mul_x;
  logic [W-1:0] mul_y;
  logic [2*W-1:0] prod;
  logic cos_le;
  logic take;

  assign fire = point_valid && cmd.load;
  assign full = (count == CW'(MAX_POINTS));
  assign rd_x = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_y = rd_data[COORD_BITS-1:0];
  assign dx = signed'({1'b0, rd_x}) - signed'({1'b0, cx});
  assign dy = signed'({1'b0, rd_y}) - signed'({1'b0, cy});
  assign dot_c = (W+1)'(rdx * dx) + (W+1)'(rdy * dy);
  assign len_c = W'(dx * dx) + W'(dy * dy);
  assign mag_a = cand_dot[W] ? W'(-cand_dot) : W'(cand_dot);
  assign mag_c = best_dot[W] ? W'(-best_dot) : W'(best_dot);
  assign prod = mul_x * mul_y;

  always_comb begin
    case (cmd.mul_phase)
      PH_SQ: begin
        mul_x = cmd.mul_q ? mag_c : mag_a;
        mul_y = mul_x;
      end
      PH_LO: begin
        mul_x = sq[W-1:0];
        mul_y = cmd.mul_q ? cand_len : best_len;
      end
      PH_HI: begin
        mul_x = sq[2*W-1:W];
        mul_y = cmd.mul_q ? cand_len : best_len;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_comb begin
    priority if (cand_dot[W] && !best_dot[W]) begin
      cos_le = 1'b1;
    end else if (!cand_dot[W] && best_dot[W]) begin
      cos_le = 1'b0;
    end else if (!cand_dot[W]) begin
      cos_le = (acc_p <= acc_q);
    end else begin
      cos_le = (acc_p >= acc_q);
    end
  end

  assign take = !cand_zero && (!found || cos_le);

  always_ff @(posedge clk) begin
    if (fire && !full) begin
      mem[count[IW-1:0]] <= {point.point_x, point.point_y};
    end
    if (cmd.rd_scan) begin
      rd_data <= mem[idx];
    end else if (cmd.rd_best) begin
      rd_data <= mem[best_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ls_cmp && (idx == '0 || rd_x < min_x)) begin
      min_x <= rd_x;
      start_idx <= idx;
    end
    if (cmd.init_walk) begin
      best_idx <= start_idx;
    end else if (cmd.decide && take) begin
      best_idx <= idx;
      best_dot <= cand_dot;
      best_len <= cand_len;
    end
    if (cmd.set_cur) begin
      cx <= rd_x;
      cy <= rd_y;
      if (cmd.first) begin
        rdx <= '0;
        rdy <= DW'(REF_START_DY);
      end else begin
        rdx <= signed'({1'b0, cx}) - signed'({1'b0, rd_x});
        rdy <= signed'({1'b0, cy}) - signed'({1'b0, rd_y});
      end
    end
    if (cmd.diff) begin
      cand_dot <= dot_c;
      cand_len <= len_c;
      cand_zero <= (dx == '0) && (dy == '0);
    end
    if (cmd.mul_en) begin
      case (cmd.mul_phase)
        PH_SQ: sq <= prod;
        PH_LO: begin
          if (cmd.mul_q) acc_q <= (3*W)'(prod);
          else acc_p <= (3*W)'(prod);
        end
        PH_HI: begin
          if (cmd.mul_q) acc_q <= acc_q + {prod, {W{1'b0}}};
          else acc_p <= acc_p + {prod, {W{1'b0}}};
        end
        default: sq <= sq;
      endcase
    end
    if (cmd.emit) begin
      hull <= '{hull_x: cx, hull_y: cy, hull_last: cmd.emit_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      round <= '0;
      idx <= '0;
      found <= 1'b0;
      hull_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count <= '0;
      end else if (fire && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.set_cur) begin
        round <= cmd.first ? '0 : round + 1'b1;
      end
      if (cmd.idx_clr || cmd.scan_start) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (cmd.decide && take) begin
        found <= 1'b1;
      end
      if (cmd.emit) begin
        hull_valid <= 1'b1;
      end else if (!hull_stall) begin
        hull_valid <= 1'b0;
      end
    end
  end

  assign status.last_beat = point_valid && point.point_last;
  assign status.last_idx = ((CW'(idx) + 1'b1) == count);
  assign status.round_done = ((round + 1'b1) >= count);
  assign status.walk_stop = !found || (best_idx == start_idx);
  assign status.out_busy = hull_valid && hull_stall;

  `GWCH_ASSERT(full_drops, fire && full && !cmd.finish |=> full,
               "store count moved past capacity")
  `GWCH_ASSERT(finish_clears, cmd.emit && cmd.emit_last |=> count == '0,
               "point count not cleared after final hull beat")
  `GWCH_ASSERT(emit_only_when_free, cmd.emit |-> !status.out_busy,
               "hull beat overwritten while stalled")
endmodule

>>> rtl/gwch_ctrl.sv
// Sequencer that drives the hull datapath through load, search and wrap rounds.
module gwch_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  gwch_pkg::status_t  status,
  output gwch_pkg::cmd_t     cmd
);
  import gwch_pkg::*;

  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_LS_RD  = 5'd1;
  localparam logic [4:0] S_LS_CMP = 5'd2;
  localparam logic [4:0] S_FETCH  = 5'd3;
  localparam logic [4:0] S_FETCH2 = 5'd4;
  localparam logic [4:0] S_RCHK   = 5'd5;
  localparam logic [4:0] S_SC_RD  = 5'd6;
  localparam logic [4:0] S_SC_DIF = 5'd7;
  localparam logic [4:0] S_SQA    = 5'd8;
  localparam logic [4:0] S_LOA    = 5'd9;
  localparam logic [4:0] S_HIA    = 5'd10;
  localparam logic [4:0] S_SQC    = 5'd11;
  localparam logic [4:0] S_LOC    = 5'd12;
  localparam logic [4:0] S_HIC    = 5'd13;
  localparam logic [4:0] S_DECIDE = 5'd14;
  localparam logic [4:0] S_REND   = 5'd15;
  localparam logic [4:0] S_EMIT   = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;
  logic last_flag;
  logic last_flag_next;
  logic first;
  logic first_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    last_flag_next = last_flag;
    first_next = first;
    cmd.emit_last = last_flag;
    cmd.first = first;
    unique case (state)
      S_LOAD: begin
        cmd.load = 1'b1;
        if (status.last_beat) begin
          cmd.idx_clr = 1'b1;
          state_next = S_LS_RD;
        end
      end
      S_LS_RD: begin
        cmd.rd_scan = 1'b1;
        state_next = S_LS_CMP;
      end
      S_LS_CMP: begin
        cmd.ls_cmp = 1'b1;
        if (status.last_idx) begin
          first_next = 1'b1;
          state_next = S_FETCH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_LS_RD;
        end
      end
      S_FETCH: begin
        cmd.init_walk = first;
        state_next = first ? S_FETCH : S_FETCH2;
        first_next = first;
        if (!first) cmd.rd_best = 1'b1;
        if (first) begin
          first_next = 1'b0;
          state_next = S_FETCH2;
          last_flag_next = 1'b1;
        end
      end
      S_FETCH2: begin
        if (last_flag) begin
          cmd.rd_best = 1'b1;
          last_flag_next = 1'b0;
          first_next = 1'b1;
        end else begin
          cmd.set_cur = 1'b1;
          first_next = 1'b0;
          state_next = S_RCHK;
        end
      end
      S_RCHK: begin
        if (status.round_done) begin
          last_flag_next = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd.rd_scan = 1'b1;
        state_next = S_SC_DIF;
      end
      S_SC_DIF: begin
        cmd.diff = 1'b1;
        state_next = S_SQA;
      end
      S_SQA: begin
        cmd.mul_en = 1'b1;
        cmd.mul_phase = PH_SQ;
        state_next = S_LOA;
      end
      S_LOA: begin
        cmd.mul_en = 1'b1;
        cmd.mul_phase = PH_LO;
        state_next = S_HIA;
      end
      S_HIA: begin
        cmd.mul_en = 1'b1;
        cmd.mul_phase = PH_HI;
        state_next = S_SQC;
      end
      S_SQC: begin
        cmd.mul_en = 1'b1;
        cmd.mul_q = 1'b1;
        cmd.mul_phase = PH_SQ;
        state_next = S_LOC;
      end
      S_LOC: begin
        cmd.mul_en = 1'b1;
        cmd.mul_q = 1'b1;
        cmd.mul_phase = PH_LO;
        state_next = S_HIC;
      end
      S_HIC: begin
        cmd.mul_en = 1'b1;
        cmd.mul_q = 1'b1;
        cmd.mul_phase = PH_HI;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (status.last_idx) begin
          state_next = S_REND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_SC_RD;
        end
      end
      S_REND: begin
        last_flag_next = status.walk_stop;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          if (last_flag) begin
            cmd.finish = 1'b1;
            last_flag_next = 1'b0;
            state_next = S_LOAD;
          end else begin
            first_next = 1'b0;
            state_next = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      last_flag <= 1'b0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      last_flag <= last_flag_next;
      first <= first_next;
    end
  end
endmodule

>>> rtl/gift_wrap_convex_hull.sv
// Top level of the gift-wrapping convex hull block.
// Points are taken one beat per cycle into a point store until a beat with
// point_last set; beats beyond MAX_POINTS are dropped, though a dropped last
// beat still closes the set. No point beat is taken while the hull walk runs.
// The walk runs longer with more stored points and hull vertices and with
// any output stall: the leftmost search reads the single store port one
// point at a time, and each wrap round visits every point with a store
// read, a difference, the one shared multiplier forming the exact cosine
// cross products in six steps, and a decision. Hull vertices leave through
// an output register, the final vertex of a set flagged by hull_last.
module gift_wrap_convex_hull #(
  parameter int MAX_POINTS = gwch_pkg::MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  gwch_pkg::point_t point,
  input  logic             point_valid,
  output logic             point_stall,
  output gwch_pkg::hull_t  hull,
  output logic             hull_valid,
  input  logic             hull_stall
);
  import gwch_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign point_stall = !cmd.load;

  gwch_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  gwch_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .point       (point),
    .point_valid (point_valid),
    .cmd         (cmd),
    .status      (status),
    .hull        (hull),
    .hull_valid  (hull_valid),
    .hull_stall  (hull_stall)
  );
endmodule

>>> dv/tb_gift_wrap_convex_hull.sv
// Self-checking testbench for the gift-wrapping convex hull block.
`timescale 1ns / 1ps

module tb_gift_wrap_convex_hull;
  import gwch_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS = 24;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  point_t point = '0;
  logic point_valid = 1'b0;
  logic point_stall;
  hull_t hull;
  logic hull_valid;
  logic hull_stall = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gift_wrap_convex_hull dut (
    .clk(clk), .rst(rst), .point(point), .point_valid(point_valid),
    .point_stall(point_stall), .hull(hull), .hull_valid(hull_valid),
    .hull_stall(hull_stall)
  );

  // Shadow of the point store used to predict each hull.
  logic [COORD_BITS-1:0] px [NPTS];
  logic [COORD_BITS-1:0] py [NPTS];
  int unsigned set_size;
  hull_t expected_hull [$];
  int mismatches = 0;
  int hull_beats = 0;
  int sets_closed = 0;
  int points_sent = 0;
  longint cycles = 0;

  // True when cosine of candidate a is not larger than that of candidate b.
  function automatic bit cos_not_above(longint da, longint la, longint db, longint lb);
    logic [127:0] lhs, rhs;
    longint ma, mb;
    ma = da < 0 ? -da : da;
    mb = db < 0 ? -db : db;
    if (da < 0 && db >= 0) return 1'b1;
    if (da >= 0 && db < 0) return 1'b0;
    lhs = 128'(ma) * 128'(ma) * 128'(lb);
    rhs = 128'(mb) * 128'(mb) * 128'(la);
    if (da >= 0) return lhs <= rhs;
    return lhs >= rhs;
  endfunction

  task automatic wrap_hull();
    int unsigned first_idx, cur, best, rounds, i;
    longint rdx, rdy, cx, cy, dx, dy, dot, len, best_dot, best_len;
    bit found;
    hull_t h;
    first_idx = 0;
    for (i = 1; i < set_size; i++)
      if (px[i] < px[first_idx]) first_idx = i;
    cur = first_idx;
    rdx = 0;
    rdy = REF_START_DY;
    h = '{px[cur], py[cur], 1'b0};
    expected_hull.push_back(h);
    best = 0;
    for (rounds = 0; rounds + 1 < set_size; rounds++) begin
      found = 0;
      best_dot = 0;
      best_len = 0;
      cx = px[cur];
      cy = py[cur];
      for (i = 0; i < set_size; i++) begin
        dx = longint'(px[i]) - cx;
        dy = longint'(py[i]) - cy;
        if (dx == 0 && dy == 0) continue;
        dot = rdx * dx + rdy * dy;
        len = dx * dx + dy * dy;
        if (!found || cos_not_above(dot, len, best_dot, best_len)) begin
          found = 1;
          best = i;
          best_dot = dot;
          best_len = len;
        end
      end
      if (!found || best == first_idx) break;
      rdx = cx - longint'(px[best]);
      rdy = cy - longint'(py[best]);
      cur = best;
      h = '{px[cur], py[cur], 1'b0};
      expected_hull.push_back(h);
    end
    expected_hull[$].hull_last = 1'b1;
    set_size = 0;
    sets_closed++;
  endtask

  task automatic take_point(point_t p);
    if (set_size < NPTS) begin
      px[set_size] = p.point_x;
      py[set_size] = p.point_y;
      set_size++;
    end
    points_sent++;
    if (p.point_last) wrap_hull();
  endtask

  // Sender: bursts with random gaps, held while a pause is asked for.
  task automatic send_point(point_t p);
    int gap;
    if ($urandom_range(3) == 0) begin
      gap = $urandom_range(1, 6);
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point <= p;
    point_valid <= 1'b1;
    do @(posedge clk); while (point_stall);
    take_point(p);
  endtask

  task automatic drain_hulls();
    if (expected_hull.size() != 0) begin
      point_valid <= 1'b0;
      while (expected_hull.size() != 0) @(posedge clk);
    end
  endtask

  // Receiver stall pattern: phases of none, light and heavy stalling.
  always @(posedge clk) begin
    int mode;
    mode = int'((cycles / 700) % 3);
    if (mode == 0) hull_stall <= 1'b0;
    else if (mode == 1) hull_stall <= ($urandom_range(3) == 0);
    else hull_stall <= ($urandom_range(3) != 0);
  end

  always @(posedge clk) begin
    hull_t e;
    cycles++;
    if (!rst && hull_valid && !hull_stall) begin
      hull_beats++;
      if (expected_hull.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected hull beat %p", hull);
      end else begin
        e = expected_hull.pop_front();
        if (hull !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("hull mismatch: expected %p got %p", e, hull);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d hull beats outstanding", expected_hull.size());
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct { logic [9:0] x; logic [9:0] y; logic last; } row_t;
  row_t directed [] = '{
    '{10'd5, 10'd5, 1'b1},
    '{10'd0, 10'd0, 1'b0}, '{10'd1023, 10'd0, 1'b0}, '{10'd1023, 10'd1023, 1'b0},
    '{10'd0, 10'd1023, 1'b0}, '{10'd512, 10'd512, 1'b1},
    '{10'd7, 10'd7, 1'b0}, '{10'd7, 10'd7, 1'b0}, '{10'd7, 10'd7, 1'b1},
    '{10'd0, 10'd0, 1'b0}, '{10'd10, 10'd10, 1'b0}, '{10'd20, 10'd20, 1'b1},
    '{10'd3, 10'd9, 1'b0}, '{10'd3, 10'd1, 1'b0}, '{10'd3, 10'd5, 1'b0},
    '{10'd8, 10'd5, 1'b1},
    '{10'h2aa, 10'h155, 1'b0}, '{10'h155, 10'h2aa, 1'b1}
  };

  initial begin
    point_t p;
    int i, n, k, sent;
    set_size = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Single point: the hull is that point alone, flagged last.
    p = '{10'd5, 10'd5, 1'b1};
    send_point(p);
    drain_hulls();
    if (hull_beats != 1) begin
      mismatches++;
      $display("single point set gave %0d beats", hull_beats);
    end
    for (i = 1; i < directed.size(); i++)
      send_point('{directed[i].x, directed[i].y, directed[i].last});
    drain_hulls();
    // Overfill the store: extra points are dropped, the last one closes the set.
    for (i = 0; i < NPTS + 4; i++) begin
      p = '{10'($urandom), 10'($urandom), i == NPTS + 3};
      send_point(p);
    end
    drain_hulls();
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = $urandom_range(1, 12);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(4) == 0)
          p = '{10'($urandom_range(3)), 10'($urandom_range(3)), k == n - 1};
        else
          p = '{10'($urandom), 10'($urandom), k == n - 1};
        send_point(p);
        sent++;
      end
      if ($urandom_range(3) == 0) drain_hulls();
    end
    point_valid <= 1'b0;
    while (expected_hull.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d points in %0d sets, %0d hull vertices checked",
             points_sent, sets_closed, hull_beats);
    if (mismatches == 0 && expected_hull.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
